@@ hw/rtl/arp_pkg.sv @@
// Shared types, constants and codes for the ARP resolver.
package arp_pkg;

  localparam int MapEntries     = 16;
  localparam int HoldoffEntries = 16;
  localparam int PendingDepth   = 16;
  localparam int MapIdxW  = $clog2(MapEntries);
  localparam int HoldIdxW = $clog2(HoldoffEntries);
  localparam int PendIdxW = $clog2(PendingDepth);
  localparam int PendCntW = $clog2(PendingDepth + 1);
  localparam int MaxResults = 16;
  localparam int FlushCntW  = $clog2(MaxResults + 1);

  localparam logic [47:0] BcastMac = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] OpSend = 2'd0;
  localparam logic [1:0] OpRecv = 2'd1;
  localparam logic [1:0] OpTick = 2'd2;

  localparam logic [1:0] FtArp  = 2'd0;
  localparam logic [1:0] FtIpv4 = 2'd1;

  localparam logic [15:0] OpcRequest = 16'd1;
  localparam logic [15:0] OpcReply   = 16'd2;

  localparam logic [1:0] KindFrame   = 2'd0;
  localparam logic [1:0] KindRequest = 2'd1;
  localparam logic [1:0] KindReply   = 2'd2;
  localparam logic [1:0] KindDeliver = 2'd3;

  localparam logic [1:0] CfgOwnMac   = 2'd0;
  localparam logic [1:0] CfgOwnIp    = 2'd1;
  localparam logic [1:0] CfgLifetime = 2'd2;
  localparam logic [1:0] CfgHoldoff  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;       // capture input event
    logic tick;        // advance clock and age tables
    logic learn;       // learn sender mapping
    logic send_cur;    // run send logic on current ip/tag
    logic emit_reply;  // emit ARP reply
    logic emit_deliver;
    logic scan_step;   // process one pending entry in flush scan
    logic scan_init;
    logic pop_flush;   // load next flushed item into current ip/tag
    logic mark_last;   // last result of event follows
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       for_us;
    logic [1:0] ftype;
    logic       ok;
    logic       is_reply;
    logic       is_req_us;
    logic       scan_done;
    logic       flush_empty;
  } status_t;

endpackage

@@ hw/rtl/arp_ctrl.sv @@
// Controller state machine for the ARP resolver.
module arp_ctrl import arp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDecode = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SFlush = 3'd3;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = SDecode;
        end
      end
      SDecode: begin
        state_d = SIdle;
        priority if (st_i.op == OpSend) begin
          cmd_o.send_cur  = 1'b1;
          cmd_o.mark_last = 1'b1;
        end else if (st_i.op == OpTick) begin
          cmd_o.tick = 1'b1;
        end else if (st_i.op == OpRecv && st_i.for_us && st_i.ok) begin
          if (st_i.ftype == FtArp) begin
            cmd_o.learn = 1'b1;
            if (st_i.is_reply) begin
              cmd_o.scan_init = 1'b1;
              state_d = SScan;
            end else if (st_i.is_req_us) begin
              cmd_o.emit_reply = 1'b1;
              cmd_o.mark_last  = 1'b1;
            end
          end else if (st_i.ftype == FtIpv4) begin
            cmd_o.emit_deliver = 1'b1;
            cmd_o.mark_last    = 1'b1;
          end
        end else begin
          // drop unknown ops, frames that are not for us and frames that failed parsing
          state_d = SIdle;
        end
      end
      SScan: begin
        if (st_i.scan_done) begin
          if (st_i.flush_empty) begin
            state_d = SIdle;
          end else begin
            cmd_o.pop_flush = 1'b1;
            state_d = SFlush;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      SFlush: begin
        cmd_o.send_cur  = 1'b1;
        cmd_o.mark_last = st_i.flush_empty;
        if (st_i.flush_empty) begin
          state_d = SIdle;
        end else begin
          cmd_o.pop_flush = 1'b1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

@@ hw/rtl/arp_dp.sv @@
// Datapath for the ARP resolver: config, tables, pending queue, flush buffer and result register.
module arp_dp import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     st_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] next_hop_ip_i,
  input  logic [15:0] datagram_tag_i,
  input  logic [15:0] tick_ms_i,
  input  logic [47:0] dst_mac_i,
  input  logic [1:0]  frame_type_i,
  input  logic        parse_ok_i,
  input  logic [15:0] arp_opcode_i,
  input  logic [31:0] sender_ip_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] target_ip_i,
  output logic        valid_o,
  output logic [1:0]  kind_o,
  output logic [47:0] frame_dst_mac_o,
  output logic [31:0] arp_target_ip_o,
  output logic [47:0] arp_target_mac_o,
  output logic [15:0] out_tag_o,
  output logic        last_o
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic [23:0] life_q, hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
      life_q    <= 24'd30000;
      hold_q    <= 24'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOwnMac:   own_mac_q <= cfg_data_i;
        CfgOwnIp:    own_ip_q  <= cfg_data_i[31:0];
        CfgLifetime: life_q    <= cfg_data_i[23:0];
        CfgHoldoff:  hold_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Latched event
  logic [1:0]  op_q, ft_q;
  logic        ok_q;
  logic [15:0] opc_q, tag_q, tick_q;
  logic [31:0] nh_q, sip_q, tip_q;
  logic [47:0] dmac_q, smac_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= op_i; ft_q <= frame_type_i; ok_q <= parse_ok_i;
      opc_q <= arp_opcode_i; tag_q <= datagram_tag_i; tick_q <= tick_ms_i;
      nh_q <= next_hop_ip_i; sip_q <= sender_ip_i; tip_q <= target_ip_i;
      dmac_q <= dst_mac_i; smac_q <= sender_mac_i;
    end
  end

  // Tables
  logic [47:0] now_q;
  logic [MapEntries-1:0]     mv_q;
  logic [31:0] mip_q [MapEntries];
  logic [47:0] mmac_q [MapEntries];
  logic [47:0] mat_q [MapEntries];
  logic [HoldoffEntries-1:0] hv_q;
  logic [31:0] hip_q [HoldoffEntries];
  logic [47:0] hat_q [HoldoffEntries];
  logic [31:0] pip_q [PendingDepth];
  logic [15:0] ptag_q [PendingDepth];
  logic [PendCntW-1:0] pcnt_q;

  // Flush buffer and scan pointers
  logic [31:0] fip_q [MaxResults];
  logic [15:0] ftag_q [MaxResults];
  logic [FlushCntW-1:0] fn_q, frd_q;
  logic [PendCntW-1:0]  rd_q, wr_q;
  logic [31:0] cur_ip_q;
  logic [15:0] cur_tag_q;

  logic [31:0] look_ip;
  assign look_ip = (op_q == OpSend) ? nh_q : cur_ip_q;
  logic [15:0] look_tag;
  assign look_tag = (op_q == OpSend) ? tag_q : cur_tag_q;

  logic              m_hit, l_hit, m_free_ok, h_hit, h_free_ok;
  logic [MapIdxW-1:0]  m_idx, l_idx, m_free;
  logic [HoldIdxW-1:0] h_free;

  always_comb begin
    m_hit = 1'b0; m_idx = '0; l_hit = 1'b0; l_idx = '0;
    m_free_ok = 1'b0; m_free = '0;
    for (int i = MapEntries - 1; i >= 0; i--) begin
      if (mv_q[i] && mip_q[i] == look_ip) begin
        m_hit = 1'b1; m_idx = MapIdxW'(i);
      end
      if (mv_q[i] && mip_q[i] == sip_q) begin
        l_hit = 1'b1; l_idx = MapIdxW'(i);
      end
      if (!mv_q[i]) begin
        m_free_ok = 1'b1; m_free = MapIdxW'(i);
      end
    end
    h_hit = 1'b0; h_free_ok = 1'b0; h_free = '0;
    for (int i = HoldoffEntries - 1; i >= 0; i--) begin
      if (hv_q[i] && hip_q[i] == look_ip) h_hit = 1'b1;
      if (!hv_q[i]) begin
        h_free_ok = 1'b1; h_free = HoldIdxW'(i);
      end
    end
  end

  logic [47:0] now_d;
  assign now_d = now_q + 48'(tick_q);

  logic scan_match;
  assign scan_match = (pip_q[rd_q[PendIdxW-1:0]] == sip_q) &&
                      (fn_q < FlushCntW'(MaxResults));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0; mv_q <= '0; hv_q <= '0; pcnt_q <= '0;
      valid_o <= 1'b0;
      fn_q <= '0; frd_q <= '0; rd_q <= '0; wr_q <= '0;
    end else begin
      // a send that misses the map and hits the holdoff table stays silent
      valid_o <= cmd_i.emit_reply | cmd_i.emit_deliver |
                 (cmd_i.send_cur & (m_hit | !h_hit));
      if (cmd_i.tick) begin
        now_q <= now_d;
        for (int i = 0; i < MapEntries; i++)
          if ((now_d - mat_q[i]) >= 48'(life_q)) mv_q[i] <= 1'b0;
        for (int i = 0; i < HoldoffEntries; i++)
          if ((now_d - hat_q[i]) >= 48'(hold_q)) hv_q[i] <= 1'b0;
      end
      if (cmd_i.learn && (l_hit || m_free_ok)) begin
        mv_q[l_hit ? l_idx : m_free] <= 1'b1;
      end
      if (cmd_i.send_cur) begin
        if (!m_hit) begin
          if (pcnt_q < PendCntW'(PendingDepth)) begin
            pcnt_q <= pcnt_q + 1'b1;
          end
          if (!h_hit && h_free_ok) hv_q[h_free] <= 1'b1;
        end
      end
      if (cmd_i.scan_init) begin
        rd_q <= '0; wr_q <= '0; fn_q <= '0; frd_q <= '0;
      end
      if (cmd_i.scan_step) begin
        rd_q <= rd_q + 1'b1;
        if (scan_match) fn_q <= fn_q + 1'b1;
        else wr_q <= wr_q + 1'b1;
      end
      if (st_o.scan_done && !cmd_i.scan_step && cmd_i.pop_flush && frd_q == '0)
        pcnt_q <= wr_q;
      else if (st_o.scan_done && fn_q == '0 && !cmd_i.send_cur)
        pcnt_q <= wr_q;
      if (cmd_i.pop_flush) frd_q <= frd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.learn && (l_hit || m_free_ok)) begin
      mip_q[l_hit ? l_idx : m_free]  <= sip_q;
      mmac_q[l_hit ? l_idx : m_free] <= smac_q;
      mat_q[l_hit ? l_idx : m_free]  <= now_q;
    end
    if (cmd_i.send_cur && !m_hit) begin
      if (pcnt_q < PendCntW'(PendingDepth)) begin
        pip_q[pcnt_q[PendIdxW-1:0]]  <= look_ip;
        ptag_q[pcnt_q[PendIdxW-1:0]] <= look_tag;
      end
      if (!h_hit && h_free_ok) begin
        hip_q[h_free] <= look_ip;
        hat_q[h_free] <= now_q;
      end
    end
    if (cmd_i.scan_step) begin
      if (scan_match) begin
        fip_q[fn_q[FlushCntW-2:0]]  <= pip_q[rd_q[PendIdxW-1:0]];
        ftag_q[fn_q[FlushCntW-2:0]] <= ptag_q[rd_q[PendIdxW-1:0]];
      end else begin
        pip_q[wr_q[PendIdxW-1:0]]  <= pip_q[rd_q[PendIdxW-1:0]];
        ptag_q[wr_q[PendIdxW-1:0]] <= ptag_q[rd_q[PendIdxW-1:0]];
      end
    end
    if (cmd_i.pop_flush) begin
      cur_ip_q  <= fip_q[frd_q[FlushCntW-2:0]];
      cur_tag_q <= ftag_q[frd_q[FlushCntW-2:0]];
    end
    // Result register
    if (cmd_i.send_cur) begin
      if (m_hit) begin
        kind_o <= KindFrame; frame_dst_mac_o <= mmac_q[m_idx];
        arp_target_ip_o <= '0; out_tag_o <= look_tag;
      end else begin
        kind_o <= KindRequest; frame_dst_mac_o <= BcastMac;
        arp_target_ip_o <= look_ip; out_tag_o <= '0;
      end
      arp_target_mac_o <= '0;
    end else if (cmd_i.emit_reply) begin
      kind_o <= KindReply; frame_dst_mac_o <= smac_q;
      arp_target_ip_o <= sip_q; arp_target_mac_o <= smac_q; out_tag_o <= '0;
    end else if (cmd_i.emit_deliver) begin
      kind_o <= KindDeliver; frame_dst_mac_o <= '0;
      arp_target_ip_o <= '0; arp_target_mac_o <= '0; out_tag_o <= tag_q;
    end
    // A request that claims a free holdoff slot silences every later
    // flushed send for the same address, so it ends the event.
    last_o <= cmd_i.mark_last | (cmd_i.send_cur & !m_hit & !h_hit & h_free_ok);
  end

  assign st_o.op          = op_q;
  assign st_o.for_us      = (dmac_q == own_mac_q) || (dmac_q == BcastMac);
  assign st_o.ftype       = ft_q;
  assign st_o.ok          = ok_q;
  assign st_o.is_reply    = (opc_q == OpcReply);
  assign st_o.is_req_us   = (opc_q == OpcRequest) && (tip_q == own_ip_q);
  assign st_o.scan_done   = (rd_q >= pcnt_q);
  assign st_o.flush_empty = (frd_q >= fn_q);

endmodule

@@ hw/rtl/arp_resolver_with_pending_queue.sv @@
// Top level of the ARP resolver with pending datagram queue.
//   channel  direction  handshake            payload
//   event    in         start / busy         op_i .. target_ip_i
//   result   out        valid_o strobe       kind_o .. last_o
//   config   in         cfg_we_i, cfg_idx_i  cfg_data_i
// A send, receive or tick event passes through the latch and decode states. A
// reply adds a compaction scan over the queued datagrams, then a send for each
// flushed datagram.
// Reset clears tables, queue count and clock; the block is ready at once.
// Results appear as one-cycle strobes; the receiver cannot stall them.
module arp_resolver_with_pending_queue import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] next_hop_ip_i,
  input  logic [15:0] datagram_tag_i,
  input  logic [15:0] tick_ms_i,
  input  logic [47:0] dst_mac_i,
  input  logic [1:0]  frame_type_i,
  input  logic        parse_ok_i,
  input  logic [15:0] arp_opcode_i,
  input  logic [31:0] sender_ip_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] target_ip_i,
  output logic        valid_o,
  output logic [1:0]  kind_o,
  output logic [47:0] frame_dst_mac_o,
  output logic [31:0] arp_target_ip_o,
  output logic [47:0] arp_target_mac_o,
  output logic [15:0] out_tag_o,
  output logic        last_o
);

  cmd_t    cmd;
  status_t st;

  // Sequence each event through decode, scan and flush
  arp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .st_i(st), .cmd_o(cmd)
  );

  arp_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .op_i, .next_hop_ip_i, .datagram_tag_i, .tick_ms_i, .dst_mac_i,
    .frame_type_i, .parse_ok_i, .arp_opcode_i, .sender_ip_i, .sender_mac_i,
    .target_ip_i,
    .valid_o, .kind_o, .frame_dst_mac_o, .arp_target_ip_o, .arp_target_mac_o,
    .out_tag_o, .last_o
  );

endmodule
